### hw/rtl/tpm_pkg.sv
package tpm_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(NUM_SLOTS);
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int TICK_W      = 32;
    localparam int TAG_W       = 32;
    localparam int DELAY_W     = 16;
    localparam int TOTAL_W     = 5;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_CREATE = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [2:0] EV_CREATED     = 3'd0;
    localparam logic [2:0] EV_CREATE_FAIL = 3'd1;
    localparam logic [2:0] EV_DELETED     = 3'd2;
    localparam logic [2:0] EV_DEL_IGNORED = 3'd3;
    localparam logic [2:0] EV_EXPIRED     = 3'd4;
    localparam logic [2:0] EV_TICK_IDLE   = 3'd5;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   user_tag;
        logic [3:0]         slot;
    } req_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [3:0]         slot_id;
        logic [TAG_W-1:0]   tag_out;
        logic [TOTAL_W-1:0] active_count;
        logic [TICK_W-1:0]  tick_now;
        logic               last;
    } res_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              load;
        logic              rotate;
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] expiry;
        logic [TAG_W-1:0]  tag;
    } bcast_t;

    // entry handed from cell to cell around the ring
    typedef struct packed {
        logic              expired;
        logic [TICK_W-1:0] late;
        logic [IDX_W-1:0]  idx;
    } ring_t;

    typedef struct packed {
        logic             busy;
        logic             expired;
        logic [CNT_W-1:0] rank;
        logic [TAG_W-1:0] tag;
    } cell_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_LOAD,
        ST_ROTATE,
        ST_EMIT
    } state_t;

endpackage

### hw/rtl/tpm_cell.sv
module tpm_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tpm_pkg::IDX_W-1:0]  cell_idx,
    input  tpm_pkg::bcast_t            bcast,
    input  logic                       wr,
    input  logic                       clr,
    input  tpm_pkg::ring_t             ring_in,
    output tpm_pkg::ring_t             ring_out,
    output tpm_pkg::cell_stat_t        stat
);

    logic                             busy_reg, busy_next;
    logic                             expired_reg, expired_next;
    logic [tpm_pkg::CNT_W-1:0]        rank_reg, rank_next;
    tpm_pkg::ring_t                   ring_reg, ring_next;
    logic [tpm_pkg::TICK_W-1:0]       expiry_reg, expiry_next;
    logic [tpm_pkg::TAG_W-1:0]        tag_reg, tag_next;
    logic [tpm_pkg::TICK_W-1:0]       late_reg, late_next;
    logic [tpm_pkg::TICK_W-1:0]       late_w;
    logic                             beats;

    assign late_w = bcast.tick - expiry_reg;

    // incoming entry ranks ahead of ours: later overdue, or equal and lower slot
    assign beats = ring_in.expired &&
                   ((ring_in.late > late_reg) ||
                    ((ring_in.late == late_reg) && (ring_in.idx < cell_idx)));

    always_comb
    begin
        busy_next    = busy_reg;
        expired_next = expired_reg;
        rank_next    = rank_reg;
        ring_next    = ring_reg;
        expiry_next  = expiry_reg;
        tag_next     = tag_reg;
        late_next    = late_reg;

        if (bcast.load)
        begin
            late_next         = late_w;
            expired_next      = busy_reg && !late_w[tpm_pkg::TICK_W-1];
            rank_next         = '0;
            ring_next.expired = busy_reg && !late_w[tpm_pkg::TICK_W-1];
            ring_next.late    = late_w;
            ring_next.idx     = cell_idx;
        end
        else if (bcast.rotate)
        begin
            ring_next = ring_in;
            if (beats)
            begin
                rank_next = rank_reg + tpm_pkg::CNT_W'(1);
            end
        end

        if (wr)
        begin
            busy_next   = 1'b1;
            expiry_next = bcast.expiry;
            tag_next    = bcast.tag;
        end
        if (clr)
        begin
            busy_next    = 1'b0;
            expired_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            expired_reg <= 1'b0;
            rank_reg    <= '0;
            ring_reg    <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            expired_reg <= expired_next;
            rank_reg    <= rank_next;
            ring_reg    <= ring_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        tag_reg    <= tag_next;
        late_reg   <= late_next;
    end

    assign ring_out     = ring_reg;
    assign stat.busy    = busy_reg;
    assign stat.expired = expired_reg;
    assign stat.rank    = rank_reg;
    assign stat.tag     = tag_reg;

endmodule

### hw/rtl/timer_pool_manager_core.sv
// Pool of one-shot timers, one slot per cell in a ring of cells.
// Request channel: req / req_valid / req_stall. A transfer takes one request:
// tick, create or delete (type 3 is dropped with no result).
// Result channel: res / res_valid / res_stall, one output register.
// Create and delete: one result, written to the output register from the
// command state once that register is free.
// Tick: a load step latches how late each slot is; in the rotate step the
// cells pass their entries around the ring and each counts how many expired
// entries rank ahead of it; the emit step then puts out one result per
// expired slot, the slot whose rank matches (or one "no expiry" result).
// One request is in work at a time; a new one is taken once the last result
// of the previous one sits in the output register, even if it is not taken.
// A stalled result holds in the output register and the sequence waits.
// Reset frees all slots and clears the tick counter and the active count.
module timer_pool_manager_core (
    input  logic           clk,
    input  logic           rst_n,
    input  tpm_pkg::req_t  req,
    input  logic           req_valid,
    output logic           req_stall,
    output tpm_pkg::res_t  res,
    output logic           res_valid,
    input  logic           res_stall
);

    localparam int N = tpm_pkg::NUM_SLOTS;

    tpm_pkg::state_t                 state_reg, state_next;
    tpm_pkg::req_t                   req_reg, req_next;
    logic [tpm_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [tpm_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic [tpm_pkg::CNT_W-1:0]       rot_cnt_reg, rot_cnt_next;
    logic [tpm_pkg::CNT_W-1:0]       emit_cnt_reg, emit_cnt_next;
    logic                            res_valid_reg, res_valid_next;
    tpm_pkg::res_t                   res_reg, res_next;

    tpm_pkg::bcast_t                 bcast;
    tpm_pkg::ring_t                  ring [N];
    tpm_pkg::cell_stat_t             stat [N];
    logic [N-1:0]                    wr_vec;
    logic [N-1:0]                    clr_vec;
    logic [N-1:0]                    busy_vec;
    logic [N-1:0]                    hit_cur;
    logic [N-1:0]                    hit_nxt;
    logic                            free_found;
    logic [tpm_pkg::IDX_W-1:0]       free_idx;
    logic [tpm_pkg::IDX_W-1:0]       hit_idx;
    logic [tpm_pkg::TAG_W-1:0]       hit_tag;
    logic [tpm_pkg::CNT_W-1:0]       emit_cnt_inc;
    logic                            last_exp;
    logic                            out_free;
    logic [tpm_pkg::IDX_W-1:0]       del_idx;
    logic                            del_hit;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            tpm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (tpm_pkg::IDX_W'(g)),
                .bcast    (bcast),
                .wr       (wr_vec[g]),
                .clr      (clr_vec[g]),
                .ring_in  (ring[(g + N - 1) % N]),
                .ring_out (ring[g]),
                .stat     (stat[g])
            );
        end
    endgenerate

    assign emit_cnt_inc = emit_cnt_reg + tpm_pkg::CNT_W'(1);

    always_comb
    begin
        busy_vec   = '0;
        hit_cur    = '0;
        hit_nxt    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        hit_idx    = '0;
        hit_tag    = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            busy_vec[i] = stat[i].busy;
            hit_cur[i]  = stat[i].expired && (stat[i].rank == emit_cnt_reg);
            hit_nxt[i]  = stat[i].expired && (stat[i].rank == emit_cnt_inc);
            if (!stat[i].busy)
            begin
                free_found = 1'b1;
                free_idx   = tpm_pkg::IDX_W'(i);
            end
        end
        // ranks of expired cells are unique, so at most one hit
        for (int i = 0; i < N; i++)
        begin
            if (hit_cur[i])
            begin
                hit_idx = hit_idx | tpm_pkg::IDX_W'(i);
                hit_tag = hit_tag | stat[i].tag;
            end
        end
    end

    assign last_exp = !(|hit_nxt) ||
                      (emit_cnt_reg == tpm_pkg::CNT_W'(tpm_pkg::MAX_RESULTS - 1));
    assign del_idx  = req_reg.slot[tpm_pkg::IDX_W-1:0];
    assign del_hit  = (int'(req_reg.slot) < N) && busy_vec[del_idx];
    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        tick_next      = tick_reg;
        total_next     = total_reg;
        rot_cnt_next   = rot_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        wr_vec         = '0;
        clr_vec        = '0;
        req_stall      = (state_reg != tpm_pkg::ST_IDLE);

        bcast.load   = 1'b0;
        bcast.rotate = 1'b0;
        bcast.tick   = tick_reg;
        bcast.expiry = tick_reg + tpm_pkg::TICK_W'(req_reg.delay);
        bcast.tag    = req_reg.user_tag;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            tpm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    case (req.req_type)
                        tpm_pkg::REQ_TICK:   state_next = tpm_pkg::ST_LOAD;
                        tpm_pkg::REQ_CREATE: state_next = tpm_pkg::ST_CMD;
                        tpm_pkg::REQ_DELETE: state_next = tpm_pkg::ST_CMD;
                        default:             state_next = tpm_pkg::ST_IDLE;
                    endcase
                end
            end

            tpm_pkg::ST_CMD:
            begin
                if (out_free)
                begin
                    res_valid_next        = 1'b1;
                    res_next.tick_now     = tick_reg;
                    res_next.last         = 1'b1;
                    res_next.tag_out      = '0;
                    res_next.slot_id      = '0;
                    res_next.active_count = total_reg;
                    if (req_reg.req_type == tpm_pkg::REQ_CREATE)
                    begin
                        if (free_found)
                        begin
                            wr_vec[free_idx]      = 1'b1;
                            total_next            = total_reg + tpm_pkg::TOTAL_W'(1);
                            res_next.event_res    = tpm_pkg::EV_CREATED;
                            res_next.slot_id      = 4'(free_idx);
                            res_next.tag_out      = req_reg.user_tag;
                            res_next.active_count = total_reg + tpm_pkg::TOTAL_W'(1);
                        end
                        else
                        begin
                            res_next.event_res = tpm_pkg::EV_CREATE_FAIL;
                        end
                    end
                    else
                    begin
                        res_next.slot_id = req_reg.slot;
                        if (del_hit)
                        begin
                            clr_vec[del_idx]      = 1'b1;
                            total_next            = total_reg - tpm_pkg::TOTAL_W'(1);
                            res_next.event_res    = tpm_pkg::EV_DELETED;
                            res_next.active_count = total_reg - tpm_pkg::TOTAL_W'(1);
                        end
                        else
                        begin
                            res_next.event_res = tpm_pkg::EV_DEL_IGNORED;
                        end
                    end
                    state_next = tpm_pkg::ST_IDLE;
                end
            end

            tpm_pkg::ST_LOAD:
            begin
                bcast.load    = 1'b1;
                bcast.tick    = tick_reg + tpm_pkg::TICK_W'(1);
                tick_next     = tick_reg + tpm_pkg::TICK_W'(1);
                rot_cnt_next  = '0;
                emit_cnt_next = '0;
                state_next    = (N > 1) ? tpm_pkg::ST_ROTATE : tpm_pkg::ST_EMIT;
            end

            tpm_pkg::ST_ROTATE:
            begin
                bcast.rotate = 1'b1;
                rot_cnt_next = rot_cnt_reg + tpm_pkg::CNT_W'(1);
                if (rot_cnt_reg == tpm_pkg::CNT_W'(N - 2))
                begin
                    state_next = tpm_pkg::ST_EMIT;
                end
            end

            tpm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next    = 1'b1;
                    res_next.tick_now = tick_reg;
                    if (|hit_cur)
                    begin
                        clr_vec               = hit_cur;
                        total_next            = total_reg - tpm_pkg::TOTAL_W'(1);
                        res_next.event_res    = tpm_pkg::EV_EXPIRED;
                        res_next.slot_id      = 4'(hit_idx);
                        res_next.tag_out      = hit_tag;
                        res_next.active_count = total_reg - tpm_pkg::TOTAL_W'(1);
                        res_next.last         = last_exp;
                        emit_cnt_next         = emit_cnt_inc;
                        if (last_exp)
                        begin
                            state_next = tpm_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        res_next.event_res    = tpm_pkg::EV_TICK_IDLE;
                        res_next.slot_id      = '0;
                        res_next.tag_out      = '0;
                        res_next.active_count = total_reg;
                        res_next.last         = 1'b1;
                        state_next            = tpm_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = tpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpm_pkg::ST_IDLE;
            tick_reg      <= '0;
            total_reg     <= '0;
            rot_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            total_reg     <= total_next;
            rot_cnt_reg   <= rot_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule
